// File: hw/rtl/geint_pkg.sv
// ----------------------------------------------------------------------------
// geint_pkg: shared definitions for the GPIO / external interrupt block
// Command codes, register word indexes, reset defaults and pin helpers.
// ----------------------------------------------------------------------------
package geint_pkg;

   localparam int DEF_REG_WORDS  = 64;
   localparam int DEF_EINT_LINES = 24;

   typedef logic [1:0]  cmd_type;
   typedef logic [5:0]  waddr_type;
   typedef logic [31:0] word_type;

   localparam cmd_type CMD_READ  = 2'd0;
   localparam cmd_type CMD_WRITE = 2'd1;
   localparam cmd_type CMD_EVENT = 2'd2;
   localparam cmd_type CMD_NOP   = 2'd3;

   localparam waddr_type W_PORTA_CON = 6'd0;
   localparam waddr_type W_PORTD_DAT = 6'd13;
   localparam waddr_type W_PORTD_UP  = 6'd14;
   localparam waddr_type W_ECON      = 6'd16;
   localparam waddr_type W_EDAT      = 6'd17;
   localparam waddr_type W_PORTG_UP  = 6'd26;
   localparam waddr_type W_MISC      = 6'd32;
   localparam waddr_type W_MASK      = 6'd41;
   localparam waddr_type W_PEND      = 6'd42;
   localparam waddr_type W_ID        = 6'd44;
   localparam waddr_type W_STATUS1   = 6'd45;

   localparam word_type MASK_RESET = 32'h00ff_fff0;

   // Power-on contents of a word that has never been written.
   function automatic word_type reset_word(input waddr_type addr, input word_type chip_id);
      word_type val;
      val = '0;
      case (addr)
         W_PORTA_CON: val = 32'h007f_ffff;
         W_PORTD_DAT: val = 32'h0000_fefc;
         W_PORTD_UP:  val = 32'h0000_f000;
         W_PORTG_UP:  val = 32'h0000_f800;
         W_MISC:      val = 32'h0001_0330;
         W_MASK:      val = MASK_RESET;
         W_ID:        val = chip_id;
         W_STATUS1:   val = 32'h0000_0001;
         default:     val = '0;
      endcase
      return val;
   endfunction

   // One bit per pin whose two-bit control field selects output mode.
   function automatic logic [15:0] output_pins(input word_type con);
      logic [15:0] m;
      for (int b = 0; b < 16; b++) begin
         m[b] = (con[2*b +: 2] == 2'b01);
      end
      return m;
   endfunction

endpackage

// File: hw/rtl/geint_req_if.sv
// ----------------------------------------------------------------------------
// geint_req_if: request channel
// Valid/ready channel carrying one bus access or interrupt event.
// ----------------------------------------------------------------------------
interface geint_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [5:0] word_address;
   logic [31:0] write_data;
   logic [4:0] line_number;
   logic       line_level;

   modport source (output valid, command, word_address, write_data, line_number,
                   line_level, input ready);
   modport sink   (input valid, command, word_address, write_data, line_number,
                   line_level, output ready);
endinterface

// File: hw/rtl/geint_rsp_if.sv
// ----------------------------------------------------------------------------
// geint_rsp_if: response channel
// Valid/ready channel carrying read data and the cascaded interrupt lines.
// ----------------------------------------------------------------------------
interface geint_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [5:0]  irq_lines;

   modport source (output valid, read_data, irq_lines, input ready);
   modport sink   (input valid, read_data, irq_lines, output ready);
endinterface

// File: hw/rtl/gpio_eint_register_block_core.sv
// ----------------------------------------------------------------------------
// gpio_eint_register_block_core: GPIO register file with interrupt cascade
// Bus reads and writes of a 32-bit register file plus external interrupt
// events; every request answers with read data and six cascaded IRQ lines.
// ----------------------------------------------------------------------------
//
//   channel   direction  carries
//   -------   ---------  ----------------------------------------------------
//   req_if    in         command, word_address, write_data, line_number, level
//   rsp_if    out        read_data, irq_lines
//   csr_*     in         chip_id value for the identification word
//
// A request is accepted, then finished in the second stage: the accept cycle launches the RAM read of the
// addressed word and of the word below it; the second stage merges, writes back
// and loads the response register. The next request is taken right after.
// A full response register that is not taken holds the second stage, and the
// request side waits. Reset clears the per-word written bits, so unwritten
// words read their defaults at once; there is no clearing pass.
//
module gpio_eint_register_block_core #(
   parameter int REG_WORDS  = geint_pkg::DEF_REG_WORDS,
   parameter int EINT_LINES = geint_pkg::DEF_EINT_LINES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  geint_pkg::word_type csr_wdata,
   geint_req_if.sink           req_if,
   geint_rsp_if.source         rsp_if
);

   import geint_pkg::*;

   localparam int AW = $clog2(REG_WORDS);
   localparam int LW = $clog2(EINT_LINES);
   localparam logic [6:0] WORD_LIMIT = 7'(REG_WORDS);
   localparam logic [5:0] LINE_LIMIT = 6'(EINT_LINES);

   // Second stage: the accepted request waiting on RAM data.
   logic      busy_ff, busy_in;
   cmd_type   cmd_ff;
   waddr_type addr_ff;
   word_type  wdata_ff;
   logic [4:0] line_ff;
   logic      lvl_ff;

   // Words written since reset; an unwritten word reads its default.
   logic [REG_WORDS-1:0] written_ff, written_in;
   word_type chip_id_ff, chip_id_in;

   // Mask and pending live in flops: the cascade needs them on every request.
   logic [31:4]           mask_ff, mask_in;
   logic [EINT_LINES-1:0] pend_ff, pend_in;

   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_data_ff, rsp_data_in;
   logic [5:0] rsp_irq_ff, rsp_irq_in;

   logic      accept;
   logic      complete;
   waddr_type req_prev;
   waddr_type addr_prev;
   logic [AW-1:0] idx_a;
   logic [AW-1:0] idx_b;
   word_type  ram_a;
   word_type  ram_b;
   word_type  word_a;
   word_type  word_b;
   word_type  merged;
   logic [15:0] pins;
   logic      in_range;
   logic      line_ok;
   logic      ram_we;
   word_type  read_val;
   word_type  pend_word;
   word_type  masked;

   // Interlock: RAM reads only on accept, writes only on complete, never together.
   assign accept   = req_if.valid & req_if.ready;
   assign complete = busy_ff & (~rsp_valid_ff | rsp_if.ready);
   assign req_if.ready = ~busy_ff;

   assign req_prev  = req_if.word_address - 6'd1;
   assign addr_prev = addr_ff - 6'd1;
   assign idx_a     = addr_ff[AW-1:0];
   assign idx_b     = addr_prev[AW-1:0];
   assign in_range  = {1'b0, addr_ff} < WORD_LIMIT;
   assign line_ok   = lvl_ff & ({1'b0, line_ff} < LINE_LIMIT);

   geint_ram #(
      .WIDTH (32),
      .DEPTH (REG_WORDS)
   ) u_regs (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (idx_a),
      .wr_data   (merged),
      .rd_en     (accept),
      .rd_addr_a (req_if.word_address[AW-1:0]),
      .rd_addr_b (req_prev[AW-1:0]),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // Fall back to the default of any word never written.
   always_comb begin
      word_a = (in_range && written_ff[idx_a]) ? ram_a : reset_word(addr_ff, chip_id_ff);
      word_b = (in_range && addr_ff != 6'd0 && written_ff[idx_b]) ? ram_b
               : reset_word(addr_prev, chip_id_ff);
   end

   assign pins = output_pins(word_b);

   always_comb begin
      mask_in    = mask_ff;
      pend_in    = pend_ff;
      written_in = written_ff;
      chip_id_in = chip_id_ff;
      ram_we     = 1'b0;
      merged     = wdata_ff;
      read_val   = '0;
      pend_word  = 32'(pend_ff);

      if (csr_we) begin
         // Reload the ID word: drop any bus-written copy.
         chip_id_in = csr_wdata;
         written_in[W_ID[AW-1:0]] = 1'b0;
      end

      // Port data below word 32: only output-mode pins take the new value.
      if (addr_ff < 6'd32 && addr_ff[1:0] == 2'b01) begin
         merged = (word_a & ~{16'h0, pins}) | (wdata_ff & {16'h0, pins});
      end

      if (complete) begin
         unique case (cmd_ff)
            CMD_READ: begin
               if (in_range) begin
                  if (addr_ff == W_MASK) begin
                     read_val = {mask_ff, 4'h0};
                  end else if (addr_ff == W_PEND) begin
                     read_val = pend_word;
                  end else begin
                     read_val = word_a;
                  end
                  // Port E input pins 14 and 15 read high.
                  if (addr_ff == W_EDAT) begin
                     if (word_b[29:28] == 2'b00) read_val[14] = 1'b1;
                     if (word_b[31:30] == 2'b00) read_val[15] = 1'b1;
                  end
               end
            end
            CMD_WRITE: begin
               if (in_range) begin
                  if (addr_ff == W_MASK) begin
                     mask_in = wdata_ff[31:4];
                  end else if (addr_ff == W_PEND) begin
                     pend_in = pend_ff & ~wdata_ff[EINT_LINES-1:0];
                  end else begin
                     ram_we = 1'b1;
                     written_in[idx_a] = 1'b1;
                  end
               end
            end
            CMD_EVENT: begin
               if (line_ok) begin
                  pend_in[line_ff[LW-1:0]] = 1'b1;
               end
            end
            CMD_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Cascade from the state this request leaves behind.
   assign masked = 32'(pend_in) & ~{mask_in, 4'h0};

   always_comb begin
      busy_in      = accept | (busy_ff & ~complete);
      rsp_valid_in = complete | (rsp_valid_ff & ~rsp_if.ready);
      rsp_data_in  = complete ? read_val : rsp_data_ff;
      rsp_irq_in   = complete ? {|masked[23:8], |masked[7:4], masked[3:0]} : rsp_irq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
         chip_id_ff   <= '0;
         mask_ff      <= MASK_RESET[31:4];
         pend_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         written_ff   <= written_in;
         chip_id_ff   <= chip_id_in;
         mask_ff      <= mask_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload: capture on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_if.command;
         addr_ff  <= req_if.word_address;
         wdata_ff <= req_if.write_data;
         line_ff  <= req_if.line_number;
         lvl_ff   <= req_if.line_level;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_data = rsp_data_ff;
   assign rsp_if.irq_lines = rsp_irq_ff;

endmodule

// File: hw/rtl/geint_ram.sv
// ----------------------------------------------------------------------------
// geint_ram: generic synchronous RAM
// One write port, two read ports with registered data and a shared enable.
// ----------------------------------------------------------------------------
module geint_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: tb/sv/gpio_eint_register_block_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpio_eint_register_block_core_tb: self-checking bench for the GPIO block
// Walks a short directed list of bus accesses and interrupt events, then
// random access sequences in three chip_id settings. A shadow copy of the
// register file predicts every response, and both channels idle at random.
// ----------------------------------------------------------------------------
module gpio_eint_register_block_core_tb;
   import geint_pkg::*;

   localparam int REG_WORDS    = geint_pkg::DEF_REG_WORDS;
   localparam int EINT_LINES   = geint_pkg::DEF_EINT_LINES;
   localparam int PORT_WORDS   = 32;     // port control/data words live below this
   localparam int HALF_HIGH    = 5;
   localparam int HALF_LOW     = 5;
   localparam int RESET_CYCLES = 8;
   localparam int IDLE_SETTLE  = 4;      // quiet cycles around a chip_id write
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;   // cycles without any handshake
   localparam int HOLD_AT      = 300;    // response count that starts the long hold
   localparam int LONG_HOLD    = 400;
   localparam int PHASE_ITEMS  = 300;

   // Further register indexes used by the directed list.
   localparam waddr_type W_PORTA_DAT = 6'd1;
   localparam waddr_type W_PLAIN     = 6'd33;   // index mod 4 is 1, but above the ports
   localparam waddr_type W_LAST      = 6'd63;

   typedef struct packed {
      cmd_type    command;
      waddr_type  word_address;
      word_type   write_data;
      logic [4:0] line_number;
      logic       line_level;
   } request_type;

   typedef struct packed {
      word_type   read_data;
      logic [5:0] irq_lines;
   } response_type;

   typedef struct packed {
      request_type  rq;
      logic         typed;     // expected response written out below
      response_type rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   word_type csr_wdata;

   geint_req_if req_bus ();
   geint_rsp_if rsp_bus ();

   gpio_eint_register_block_core DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   // Shadow state of the block: register file and identification value.
   word_type         shadow_regs [REG_WORDS];
   word_type         shadow_chip_id;
   response_type     awaited_responses [$];
   directed_row_type directed_rows [$];
   int               requests_sent;
   int               mismatch_count;
   int               idle_cycles;
   bit               sender_burst;

   always begin
      #HALF_LOW clock = 1'b1;
      #HALF_HIGH clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Load the power-on contents, with chip_id and the identification word cleared.
   task automatic restore_defaults();
      for (int i = 0; i < REG_WORDS; i++) begin
         shadow_regs[i] = '0;
      end
      shadow_chip_id            = '0;
      shadow_regs[W_PORTA_CON]  = 32'h007f_ffff;
      shadow_regs[W_PORTD_DAT]  = 32'h0000_fefc;
      shadow_regs[W_PORTD_UP]   = 32'h0000_f000;
      shadow_regs[W_PORTG_UP]   = 32'h0000_f800;
      shadow_regs[W_MISC]       = 32'h0001_0330;
      shadow_regs[W_MASK]       = 32'h00ff_fff0;
      shadow_regs[W_ID]         = shadow_chip_id;
      shadow_regs[W_STATUS1]    = 32'h0000_0001;
   endtask

   // Apply one request to the shadow file and return the response it causes.
   function automatic response_type apply_access(input request_type rq);
      response_type rs;
      word_type     val;
      word_type     pins;
      word_type     live;
      logic [15:0]  outs;
      int           b;
      rs.read_data = '0;
      case (rq.command)
         CMD_READ: begin
            if (int'(rq.word_address) < REG_WORDS) begin
               val = shadow_regs[rq.word_address];
               // Port E pins 14 and 15 float high while in input mode.
               if (rq.word_address == W_EDAT) begin
                  if (shadow_regs[W_ECON][29:28] == 2'b00) val[14] = 1'b1;
                  if (shadow_regs[W_ECON][31:30] == 2'b00) val[15] = 1'b1;
               end
               rs.read_data = val;
            end
         end
         CMD_WRITE: begin
            if (int'(rq.word_address) < REG_WORDS) begin
               val = rq.write_data;
               if (rq.word_address == W_MASK) val[3:0] = 4'b0000;
               if (rq.word_address == W_PEND) begin
                  shadow_regs[W_PEND] = shadow_regs[W_PEND] & ~val;
               end else if (int'(rq.word_address) < PORT_WORDS &&
                            rq.word_address[1:0] == 2'b01) begin
                  // Only output-mode pins take the new data.
                  for (b = 0; b < 16; b++) begin
                     outs[b] = (shadow_regs[rq.word_address - 6'd1][2*b +: 2] == 2'b01);
                  end
                  pins = {16'h0000, outs};
                  shadow_regs[rq.word_address] =
                     (shadow_regs[rq.word_address] & ~pins) | (val & pins);
               end else begin
                  shadow_regs[rq.word_address] = val;
               end
            end
         end
         CMD_EVENT: begin
            if (rq.line_level && int'(rq.line_number) < EINT_LINES) begin
               shadow_regs[W_PEND][rq.line_number] = 1'b1;
            end
         end
         default: ;
      endcase
      live = shadow_regs[W_PEND] & ~shadow_regs[W_MASK];
      rs.irq_lines = {|live[23:8], |live[7:4], live[3:0]};
      return rs;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Fill every field at random so unused fields toggle too.
   function automatic request_type rand_request();
      request_type rq;
      rq.command      = cmd_type'($urandom_range(0, 3));
      rq.word_address = waddr_type'($urandom);
      rq.write_data   = $urandom;
      rq.line_number  = 5'($urandom);
      rq.line_level   = 1'($urandom);
      return rq;
   endfunction

   function automatic request_type shaped_request(input cmd_type cmd, input waddr_type addr);
      request_type rq;
      rq              = rand_request();
      rq.command      = cmd;
      rq.word_address = addr;
      return rq;
   endfunction

   // Offer one request after a random gap, hold it until taken, then predict.
   task automatic send_request(input request_type rq);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.command      <= rq.command;
      req_bus.word_address <= rq.word_address;
      req_bus.write_data   <= rq.write_data;
      req_bus.line_number  <= rq.line_number;
      req_bus.line_level   <= rq.line_level;
      req_bus.valid        <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      awaited_responses.push_back(apply_access(rq));
      requests_sent++;
   endtask

   // Write chip_id only once the block has answered everything.
   task automatic write_chip_id(input word_type value);
      req_bus.valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_chip_id    = value;
      shadow_regs[W_ID] = value;
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic add_row(input cmd_type cmd, input waddr_type addr, input word_type data,
                          input logic [4:0] line, input logic level, input logic typed,
                          input word_type rdata, input logic [5:0] irq);
      directed_row_type row;
      row.rq.command      = cmd;
      row.rq.word_address = addr;
      row.rq.write_data   = data;
      row.rq.line_number  = line;
      row.rq.line_level   = level;
      row.typed           = typed;
      row.rsp.read_data   = rdata;
      row.rsp.irq_lines   = irq;
      directed_rows.push_back(row);
   endtask

   // Random sequences: mostly well-formed port, interrupt and port E traffic.
   task automatic run_random_phase(input int count);
      int          target;
      int          pick;
      int          port;
      request_type rq;
      target = requests_sent + count;
      while (requests_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            // Set up a port's pin modes, drive its data and read it back.
            port = $urandom_range(0, PORT_WORDS / 4 - 1);
            send_request(shaped_request(CMD_WRITE, waddr_type'(4 * port)));
            send_request(shaped_request(CMD_WRITE, waddr_type'(4 * port + 1)));
            send_request(shaped_request(CMD_READ, waddr_type'(4 * port + 1)));
            if ($urandom_range(0, 1) == 1) begin
               send_request(shaped_request(CMD_READ, waddr_type'(4 * port)));
            end
         end else if (pick < 65) begin
            // Raise a few lines, maybe remask, read pending and clear some.
            repeat ($urandom_range(1, 4)) begin
               rq = shaped_request(CMD_EVENT, waddr_type'($urandom));
               rq.line_level = ($urandom_range(0, 3) != 0);
               send_request(rq);
            end
            if ($urandom_range(0, 2) == 0) send_request(shaped_request(CMD_WRITE, W_MASK));
            send_request(shaped_request(CMD_READ, W_PEND));
            if ($urandom_range(0, 1) == 1) begin
               rq = shaped_request(CMD_WRITE, W_PEND);
               if ($urandom_range(0, 3) == 0) rq.write_data = '1;
               send_request(rq);
            end
         end else if (pick < 75) begin
            // Port E: pin modes decide the floating bits.
            send_request(shaped_request(CMD_WRITE, W_ECON));
            if ($urandom_range(0, 1) == 1) send_request(shaped_request(CMD_WRITE, W_EDAT));
            send_request(shaped_request(CMD_READ, W_EDAT));
         end else if (pick < 85) begin
            port = $urandom_range(0, REG_WORDS - 1);
            send_request(shaped_request(CMD_WRITE, waddr_type'(port)));
            send_request(shaped_request(CMD_READ, waddr_type'(port)));
         end else begin
            repeat ($urandom_range(1, 3)) send_request(rand_request());
         end
      end
   endtask

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, one long hold, and the comparison
   // ------------------------------------------------------------------------
   initial begin : response_sink
      int           stall;
      int           taken;
      bit           sink_burst;
      response_type want;
      taken      = 0;
      sink_burst = 1'b0;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
         stall = sink_burst ? 0 : $urandom_range(0, 19);
         // Hold off long enough for the block to fill and stall its input.
         if (taken == HOLD_AT) stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         taken++;
         if (awaited_responses.size() == 0) begin
            report_mismatch("response with none awaited", rsp_bus.read_data, '0);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_bus.read_data !== want.read_data) begin
               report_mismatch("read_data", rsp_bus.read_data, want.read_data);
            end
            if (rsp_bus.irq_lines !== want.irq_lines) begin
               report_mismatch("irq_lines", word_type'(rsp_bus.irq_lines),
                               word_type'(want.irq_lines));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run when neither channel moves for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      request_type rq;
      requests_sent  = 0;
      mismatch_count = 0;
      sender_burst   = 1'b0;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_NOP;
      req_bus.word_address <= '0;
      req_bus.write_data   <= '0;
      req_bus.line_number  <= '0;
      req_bus.line_level   <= 1'b0;
      restore_defaults();

      // Directed list. After reset pending is empty and the mask covers
      // lines 4-23, so only lines 0-3 reach the cascade.
      add_row(CMD_READ,  W_PORTA_CON, 32'h0,          5'd0,  1'b0, 1'b1, 32'h007f_ffff, 6'h00);
      add_row(CMD_READ,  W_ID,        32'hffff_ffff,  5'd31, 1'b1, 1'b1, 32'h0000_0000, 6'h00);
      // Port E control is all input mode: both floating bits read high.
      add_row(CMD_READ,  W_EDAT,      32'h0,          5'd0,  1'b0, 1'b1, 32'h0000_c000, 6'h00);
      add_row(CMD_READ,  W_MASK,      32'h0,          5'd0,  1'b0, 1'b1, 32'h00ff_fff0, 6'h00);
      add_row(CMD_READ,  W_LAST,      32'h0,          5'd0,  1'b0, 1'b1, 32'h0000_0000, 6'h00);
      add_row(CMD_EVENT, W_LAST,      32'h0,          5'd0,  1'b1, 1'b1, 32'h0000_0000, 6'h01);
      // Line 23 pends but stays masked.
      add_row(CMD_EVENT, W_PORTA_CON, 32'h0,          5'd23, 1'b1, 1'b1, 32'h0000_0000, 6'h01);
      // Line past the last one, and a low level: both ignored.
      add_row(CMD_EVENT, W_PORTA_CON, 32'hffff_ffff,  5'd31, 1'b1, 1'b1, 32'h0000_0000, 6'h01);
      add_row(CMD_EVENT, W_PORTA_CON, 32'h0,          5'd5,  1'b0, 1'b1, 32'h0000_0000, 6'h01);
      add_row(CMD_READ,  W_PEND,      32'h0,          5'd0,  1'b0, 1'b1, 32'h0080_0001, 6'h01);
      // Unmask everything: line 23 reaches the top cascade bit.
      add_row(CMD_WRITE, W_MASK,      32'h0,          5'd0,  1'b0, 1'b1, 32'h0000_0000, 6'h21);
      add_row(CMD_EVENT, W_PORTA_CON, 32'h0,          5'd4,  1'b1, 1'b1, 32'h0000_0000, 6'h31);
      // Mask all: low four bits cannot be set.
      add_row(CMD_WRITE, W_MASK,      32'hffff_ffff,  5'd0,  1'b0, 1'b1, 32'h0000_0000, 6'h01);
      add_row(CMD_READ,  W_MASK,      32'h0,          5'd0,  1'b0, 1'b1, 32'hffff_fff0, 6'h01);
      add_row(CMD_EVENT, W_PORTA_CON, 32'h0,          5'd3,  1'b1, 1'b1, 32'h0000_0000, 6'h09);
      // Write one to clear every pending bit.
      add_row(CMD_WRITE, W_PEND,      32'hffff_ffff,  5'd0,  1'b0, 1'b1, 32'h0000_0000, 6'h00);
      add_row(CMD_READ,  W_PEND,      32'h0,          5'd0,  1'b0, 1'b1, 32'h0000_0000, 6'h00);
      // Port A all output: data takes the low sixteen bits only.
      add_row(CMD_WRITE, W_PORTA_CON, 32'h5555_5555,  5'd0,  1'b0, 1'b1, 32'h0000_0000, 6'h00);
      add_row(CMD_WRITE, W_PORTA_DAT, 32'hffff_ffff,  5'd0,  1'b0, 1'b0, 32'h0,         6'h00);
      add_row(CMD_READ,  W_PORTA_DAT, 32'h0,          5'd0,  1'b0, 1'b1, 32'h0000_ffff, 6'h00);
      // Port A all input: data write has no effect.
      add_row(CMD_WRITE, W_PORTA_CON, 32'h0,          5'd0,  1'b0, 1'b0, 32'h0,         6'h00);
      add_row(CMD_WRITE, W_PORTA_DAT, 32'h0,          5'd0,  1'b0, 1'b0, 32'h0,         6'h00);
      add_row(CMD_READ,  W_PORTA_DAT, 32'h0,          5'd0,  1'b0, 1'b1, 32'h0000_ffff, 6'h00);
      // Port E pin 14 output, pin 15 input: only bit 15 floats high.
      add_row(CMD_WRITE, W_ECON,      32'h1000_0000,  5'd0,  1'b0, 1'b0, 32'h0,         6'h00);
      add_row(CMD_READ,  W_EDAT,      32'h0,          5'd0,  1'b0, 1'b1, 32'h0000_8000, 6'h00);
      // Above the ports a data-like index stores plainly.
      add_row(CMD_WRITE, W_PLAIN,     32'ha5a5_a5a5,  5'd0,  1'b0, 1'b0, 32'h0,         6'h00);
      add_row(CMD_READ,  W_PLAIN,     32'h0,          5'd0,  1'b0, 1'b1, 32'ha5a5_a5a5, 6'h00);
      add_row(CMD_NOP,   W_LAST,      32'hffff_ffff,  5'd31, 1'b1, 1'b1, 32'h0000_0000, 6'h00);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed list; a typed response replaces the prediction.
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].rq);
         if (directed_rows[i].typed) begin
            awaited_responses[awaited_responses.size() - 1] = directed_rows[i].rsp;
         end
      end

      // Random phases, each under its own chip_id, extremes first.
      write_chip_id(32'hffff_ffff);
      run_random_phase(PHASE_ITEMS);
      write_chip_id(32'h0000_0000);
      run_random_phase(PHASE_ITEMS);
      write_chip_id($urandom);
      run_random_phase(PHASE_ITEMS);

      // Drop valid, drain the responses, then allow for anything stray.
      req_bus.valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
